FILE: hdl/vn3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vn3_pkg;

    localparam int FRAC_BITS   = 30;
    localparam int COMP_W      = 32;
    localparam int SUM_W       = 2 * COMP_W;
    localparam int ROOT_W      = COMP_W;
    localparam int SQRT_STAGES = ROOT_W;
    // quotient |c| * 2^F / |v| never exceeds 2^F
    localparam int Q_W         = FRAC_BITS + 1;
    localparam int DIV_STAGES  = Q_W;
    // abs, square, sum, root, divide, output
    localparam int LATENCY     = 3 + SQRT_STAGES + DIV_STAGES + 1;

    typedef struct packed {
        logic              neg;
        logic [COMP_W-1:0] mag;
    } t_comp;

    typedef struct packed {
        t_comp x;
        t_comp y;
        t_comp z;
    } t_vec;

    typedef struct packed {
        logic [2:0]        neg;
        logic [ROOT_W-1:0] root;
    } t_side;

endpackage

`default_nettype wire

FILE: hdl/vn3_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// One root bit per stage, restoring digit-by-digit square root.
module vn3_sqrt (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [vn3_pkg::SUM_W-1:0]  i_radicand,
    output logic      [vn3_pkg::ROOT_W-1:0] o_root
);
    import vn3_pkg::*;

    logic [SUM_W-1:0]  r_rad  [SQRT_STAGES-1];
    logic [ROOT_W+1:0] r_rem  [SQRT_STAGES];
    logic [ROOT_W-1:0] r_root [SQRT_STAGES];

    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
        logic [SUM_W-1:0]  p_rad;
        logic [ROOT_W+1:0] p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [ROOT_W+1:0] t_rem;
        logic [ROOT_W+1:0] trial;
        logic [ROOT_W+1:0] n_rem;
        logic [ROOT_W-1:0] n_root;

        if (g == 0) begin : g_first
            assign p_rad  = i_radicand;
            assign p_rem  = '0;
            assign p_root = '0;
        end else begin : g_next
            assign p_rad  = r_rad[g-1];
            assign p_rem  = r_rem[g-1];
            assign p_root = r_root[g-1];
        end

        // remainder stays below 2*root+1, so its top two bits are zero
        always_comb begin
            t_rem = {p_rem[ROOT_W-1:0], p_rad[SUM_W-1 -: 2]};
            trial = {p_root, 2'b01};
            if (t_rem >= trial) begin
                n_rem  = t_rem - trial;
                n_root = {p_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = t_rem;
                n_root = {p_root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
            end
        end

        if (g < SQRT_STAGES - 1) begin : g_rad
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[g] <= {p_rad[SUM_W-3:0], 2'b00};
                end
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];

endmodule

`default_nettype wire

FILE: hdl/vn3_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per stage: (a << FRAC_BITS) / d.
// The quotient fits Q_W bits, so the first partial remainder a >> 1 is below d.
module vn3_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [vn3_pkg::COMP_W-1:0] i_dividend,
    input  wire logic [vn3_pkg::ROOT_W-1:0] i_divisor,
    output logic      [vn3_pkg::Q_W-1:0]    o_quot
);
    import vn3_pkg::*;

    logic [ROOT_W-1:0] r_rem [DIV_STAGES];
    logic [Q_W-1:0]    r_low [DIV_STAGES-1];
    logic [ROOT_W-1:0] r_div [DIV_STAGES-1];
    logic [Q_W-1:0]    r_q   [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic [ROOT_W-1:0] p_rem;
        logic [Q_W-1:0]    p_low;
        logic [ROOT_W-1:0] p_div;
        logic [Q_W-1:0]    p_q;
        logic [ROOT_W:0]   t_rem;
        logic [ROOT_W-1:0] n_rem;
        logic              q_bit;

        if (g == 0) begin : g_first
            assign p_rem = {1'b0, i_dividend[COMP_W-1:1]};
            assign p_low = {i_dividend[0], {FRAC_BITS{1'b0}}};
            assign p_div = i_divisor;
            assign p_q   = '0;
        end else begin : g_next
            assign p_rem = r_rem[g-1];
            assign p_low = r_low[g-1];
            assign p_div = r_div[g-1];
            assign p_q   = r_q[g-1];
        end

        always_comb begin
            t_rem = {p_rem, p_low[Q_W-1]};
            q_bit = (t_rem >= {1'b0, p_div});
            if (q_bit) begin
                n_rem = ROOT_W'(t_rem - {1'b0, p_div});
            end else begin
                n_rem = t_rem[ROOT_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem;
                r_q[g]   <= {p_q[Q_W-2:0], q_bit};
            end
        end

        if (g < DIV_STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_low[g] <= {p_low[Q_W-2:0], 1'b0};
                    r_div[g] <= p_div;
                end
            end
        end
    end

    assign o_quot = r_q[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: hdl/vector_normalize_3d_top.sv
// channel  direction  handshake            payload
// input    in         i_valid / o_ready    i_vec_x, i_vec_y, i_vec_z
// result   out        o_valid / i_ready    o_unit_x/y/z, o_magnitude, o_zero_vector
//
// One item per cycle while the output is not stalled; stages: abs, square, sum, 32 root stages,
// 31 divide stages and output register at FRAC_BITS = 30.
// The root and divide chains, one bit per stage, set the depth.
// Synchronous active-low reset clears only the valid bits.
// The whole pipeline holds while the output register is full and not taken.
`timescale 1ns / 1ps
`default_nettype none

module vector_normalize_3d_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [vn3_pkg::COMP_W-1:0] i_vec_x,
    input  wire logic signed [vn3_pkg::COMP_W-1:0] i_vec_y,
    input  wire logic signed [vn3_pkg::COMP_W-1:0] i_vec_z,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed      [vn3_pkg::COMP_W-1:0] o_unit_x,
    output logic signed      [vn3_pkg::COMP_W-1:0] o_unit_y,
    output logic signed      [vn3_pkg::COMP_W-1:0] o_unit_z,
    output logic             [vn3_pkg::ROOT_W-1:0] o_magnitude,
    output logic                                   o_zero_vector
);
    import vn3_pkg::*;

    localparam int VEC_DLY = SQRT_STAGES + 2;

    logic               adv;
    logic [LATENCY-1:0] r_vld;
    t_vec               r_a;
    t_vec               r_vdly [VEC_DLY];
    logic [SUM_W-1:0]   r_sq [3];
    logic [SUM_W-1:0]   r_sum;
    logic [ROOT_W-1:0]  root;
    t_side              r_side [DIV_STAGES];
    logic [Q_W-1:0]     q_x, q_y, q_z;
    t_side              side_out;
    logic               zero;
    logic signed [COMP_W-1:0] r_ux, r_uy, r_uz;
    logic [ROOT_W-1:0]  r_mag;
    logic               r_zero;

    function automatic t_comp abs_comp(input logic [COMP_W-1:0] v);
        t_comp c;
        c.neg = v[COMP_W-1];
        c.mag = v[COMP_W-1] ? (~v + 1'b1) : v;
        return c;
    endfunction

    function automatic logic signed [COMP_W-1:0] signed_q(input logic neg,
                                                          input logic [Q_W-1:0] q);
        logic [COMP_W-1:0] e;
        e = COMP_W'(q);
        return neg ? (~e + 1'b1) : e;
    endfunction

    assign adv     = !r_vld[LATENCY-1] || i_ready;
    // no item is taken while reset is held
    assign o_ready = adv && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LATENCY-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a.x   <= abs_comp(i_vec_x);
            r_a.y   <= abs_comp(i_vec_y);
            r_a.z   <= abs_comp(i_vec_z);
            r_sq[0] <= r_a.x.mag * r_a.x.mag;
            r_sq[1] <= r_a.y.mag * r_a.y.mag;
            r_sq[2] <= r_a.z.mag * r_a.z.mag;
            // at most 3 * 2^62, no overflow
            r_sum   <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    for (genvar g = 0; g < VEC_DLY; g++) begin : g_vdly
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_vdly[g] <= (g == 0) ? r_a : r_vdly[(g == 0) ? 0 : g - 1];
            end
        end
    end

    vn3_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_radicand (r_sum),
        .o_root     (root)
    );

    vn3_div u_div_x (
        .i_clk(i_clk), .i_en(adv), .i_dividend(r_vdly[VEC_DLY-1].x.mag),
        .i_divisor(root), .o_quot(q_x)
    );

    vn3_div u_div_y (
        .i_clk(i_clk), .i_en(adv), .i_dividend(r_vdly[VEC_DLY-1].y.mag),
        .i_divisor(root), .o_quot(q_y)
    );

    vn3_div u_div_z (
        .i_clk(i_clk), .i_en(adv), .i_dividend(r_vdly[VEC_DLY-1].z.mag),
        .i_divisor(root), .o_quot(q_z)
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (g == 0) begin
                    r_side[g].neg  <= {r_vdly[VEC_DLY-1].x.neg, r_vdly[VEC_DLY-1].y.neg,
                                       r_vdly[VEC_DLY-1].z.neg};
                    r_side[g].root <= root;
                end else begin
                    r_side[g] <= r_side[(g == 0) ? 0 : g - 1];
                end
            end
        end
    end

    assign side_out = r_side[DIV_STAGES-1];
    // root is zero only for the zero vector
    assign zero     = (side_out.root == '0);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ux   <= zero ? '0 : signed_q(side_out.neg[2], q_x);
            r_uy   <= zero ? '0 : signed_q(side_out.neg[1], q_y);
            r_uz   <= zero ? '0 : signed_q(side_out.neg[0], q_z);
            r_mag  <= side_out.root;
            r_zero <= zero;
        end
    end

    assign o_valid       = r_vld[LATENCY-1];
    assign o_unit_x      = r_ux;
    assign o_unit_y      = r_uy;
    assign o_unit_z      = r_uz;
    assign o_magnitude   = r_mag;
    assign o_zero_vector = r_zero;

`ifndef NO_ASSERTIONS
    a_zero_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_vector |-> o_unit_x == 0 && o_unit_y == 0 && o_unit_z == 0)
        else $error("zero vector with nonzero unit output");

    a_zero_mag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_zero_vector == (o_magnitude == 0))
        else $error("zero flag disagrees with magnitude");

    a_unit_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_unit_x <= (COMP_W'(1) << FRAC_BITS)
                 && o_unit_x >= -(COMP_W'(1) << FRAC_BITS))
        else $error("unit x out of range");

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(r_vld))
        else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int F         = vn3_pkg::FRAC_BITS;
    localparam int W         = vn3_pkg::COMP_W;
    localparam int LAT       = vn3_pkg::LATENCY;
    localparam int STALL_MAX = 4000;

    typedef struct packed {
        logic signed [W-1:0] ux;
        logic signed [W-1:0] uy;
        logic signed [W-1:0] uz;
        logic [W-1:0]        mag;
        logic                zero;
    } t_norm;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic signed [W-1:0] i_vec_x = '0;
    logic signed [W-1:0] i_vec_y = '0;
    logic signed [W-1:0] i_vec_z = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic signed [W-1:0] o_unit_x;
    logic signed [W-1:0] o_unit_y;
    logic signed [W-1:0] o_unit_z;
    logic [W-1:0]        o_magnitude;
    logic                o_zero_vector;

    t_norm expected_norms[$];
    int    mismatches = 0;
    int    idle_cycles = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;

    vector_normalize_3d_top dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] b;
        rem  = n;
        root = 0;
        b    = 64'd1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic logic [W-1:0] unit_of(input logic signed [W-1:0] c,
                                              input logic [63:0] mag);
        logic [63:0] a;
        logic [63:0] q;
        a = c[W-1] ? 64'(-{{32{c[W-1]}}, c}) : 64'(c);
        q = (a << F) / mag;
        if (c[W-1]) q = -q;
        return q[W-1:0];
    endfunction

    function automatic t_norm normalize(input logic signed [W-1:0] x,
                                        input logic signed [W-1:0] y,
                                        input logic signed [W-1:0] z);
        t_norm r;
        logic [63:0] ax, ay, az, m;
        ax = x[W-1] ? 64'(-{{32{x[W-1]}}, x}) : 64'(x);
        ay = y[W-1] ? 64'(-{{32{y[W-1]}}, y}) : 64'(y);
        az = z[W-1] ? 64'(-{{32{z[W-1]}}, z}) : 64'(z);
        m  = floor_sqrt(ax * ax + ay * ay + az * az);
        r  = '0;
        if (m == 0) begin
            r.zero = 1'b1;
        end else begin
            r.ux  = unit_of(x, m);
            r.uy  = unit_of(y, m);
            r.uz  = unit_of(z, m);
            r.mag = m[W-1:0];
        end
        return r;
    endfunction

    // called and returns at a falling edge; valid stays high between back-to-back items
    task automatic send_vector(input logic signed [W-1:0] x,
                               input logic signed [W-1:0] y,
                               input logic signed [W-1:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_vec_x <= x;
        i_vec_y <= y;
        i_vec_z <= z;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_norms.push_back(normalize(x, y, z));
        @(negedge i_clk);
    endtask

    // receiver ready, randomized on each falling edge
    always @(negedge i_clk)
        i_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        t_norm want;
        t_norm got;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_unit_x, o_unit_y, o_unit_z, o_magnitude, o_zero_vector};
            if (expected_norms.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_norms.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp x=%0d y=%0d z=%0d m=%0d zero=%0b, ",
                                  "got x=%0d y=%0d z=%0d m=%0d zero=%0b"},
                                 want.ux, want.uy, want.uz, want.mag, want.zero,
                                 got.ux, got.uy, got.uz, got.mag, got.zero);
                end
            end
        end
    end

    // watchdog: cycles with no item moved on either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic signed [W-1:0] rand_comp();
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $signed($urandom_range(7)) - 3;
            3: return $signed($urandom_range(2000)) - 1000;
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic test_directed();
        send_vector(0, 0, 0);
        send_vector(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_vector(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_vector(32'sh8000_0000, 0, 0);
        send_vector(0, 32'sh7fff_ffff, 0);
        send_vector(0, 0, -1);
        send_vector(1, 0, 0);
        send_vector(-1, -1, -1);
        send_vector(3, 4, 0);
        send_vector(-3, 0, 4);
        send_vector(1, 1, 1);
        send_vector(32'sh7fff_ffff, 32'sh8000_0000, 1);
        send_vector(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f);
        send_vector(32'shffff_ffff, 0, 32'sh0000_0001);
    endtask

    task automatic test_random(input int n);
        repeat (n) send_vector(rand_comp(), rand_comp(), rand_comp());
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_norms.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 33;
        recv_idle_pct = 73;
        test_directed();
        test_random(450);
        drain();

        send_idle_pct = 73;
        recv_idle_pct = 33;
        test_random(450);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(500);
        drain();

        if (mismatches == 0 && expected_norms.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: vector_normalize_3d_top.f
hdl/vn3_pkg.sv
hdl/vn3_sqrt.sv
hdl/vn3_div.sv
hdl/vector_normalize_3d_top.sv
test/tb_top.sv
